### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");

`define ASSERT_STABLE(lbl, clk, rst_n, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error("signal changed while held");

`endif

### rtl/prfs_pkg.sv
package prfs_pkg;

  localparam int FrameWidth  = 640;
  localparam int FrameHeight = 480;
  localparam int StoreDepth  = FrameWidth * FrameHeight;
  localparam int AddrW       = $clog2(StoreDepth);
  localparam int XW          = $clog2(FrameWidth);
  localparam int YW          = $clog2(FrameHeight);
  localparam int CountW      = 20;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    OpClear  = 3'd0,
    OpLine   = 3'd1,
    OpBold   = 3'd2,
    OpRect   = 3'd3,
    OpFill   = 3'd4,
    OpCircle = 3'd5,
    OpRead   = 3'd6,
    OpNone   = 3'd7
  } opcode_e;

  typedef enum logic [0:0] {
    RegBoldHalf = 1'b0,
    RegRingBand = 1'b1
  } reg_index_e;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StLineX,
    StLineDiv,
    StStamp,
    StRectPass,
    StFill,
    StCircMul,
    StCircTest,
    StReadWait,
    StReadData,
    StDone
  } state_e;

  // One pixel write request toward the frame store.
  typedef struct packed {
    logic               en;
    logic [AddrW-1:0]   addr;
    logic [23:0]        color;
  } pix_wr_t;

  // Request and reply of the shared divider.
  typedef struct packed {
    logic        start;
    logic [21:0] num_mag;
    logic [11:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [21:0] quo;
  } div_rsp_t;

endpackage

### rtl/primitive_rasterizer_frame_store.sv
// Rasterizer with a 640x480 RGB frame store. One command is taken at a time;
// in_stall stays high until its single result has been transferred. A clear
// writes one pixel per cycle. Each x step of a line waits on the shared
// bit-serial divider; a bold line then stamps a square of half-width h around
// each point. Rectangles take one cycle per visited pixel, and a circle ring
// tests each examined pixel through the shared multiplier. A read waits for
// the registered store output and captures it into the result.
module primitive_rasterizer_frame_store
  import prfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode_i,
  input  logic [10:0] x_start_i,
  input  logic [10:0] y_start_i,
  input  logic [10:0] x_end_i,
  input  logic [10:0] y_end_i,
  input  logic [8:0]  radius_i,
  input  logic [23:0] draw_color_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] read_color_o,
  output logic [19:0] pixels_written_o
);

  logic [3:0]  bold_q;
  logic [11:0] band_q;
  pix_wr_t     wr;
  logic [AddrW-1:0] rd_addr;
  logic [23:0] rd_data;
  div_req_t    dreq;
  div_rsp_t    drsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bold_q <= 4'd5;
      band_q <= 12'd50;
    end else if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_index_i))
        RegBoldHalf: bold_q <= cfg_data_i[3:0];
        default:     band_q <= cfg_data_i;
      endcase
    end
  end

  prfs_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  prfs_store u_store (.clk_i, .wr_i(wr), .rd_addr_i(rd_addr), .rd_data_o(rd_data));

  prfs_seq u_seq (
    .clk_i, .rst_ni, .in_valid, .in_stall, .opcode_i, .x_start_i, .y_start_i,
    .x_end_i, .y_end_i, .radius_i, .draw_color_i, .bold_half_i(bold_q),
    .ring_band_i(band_q), .out_valid, .out_stall, .read_color_o,
    .pixels_written_o, .wr_o(wr), .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .div_req_o(dreq), .div_rsp_i(drsp)
  );

endmodule

### rtl/prfs_div.sv
module prfs_div
  import prfs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [21:0] quo_q, quo_d;
  logic [12:0] rem_q, rem_d;
  logic [11:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [12:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[11:0], quo_q[21]};
    if (req_i.start) begin
      quo_d  = req_i.num_mag;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 5'd22;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[20:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[20:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

### rtl/prfs_store.sv
module prfs_store
  import prfs_pkg::*;
(
  input  logic             clk_i,
  input  pix_wr_t          wr_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [23:0]      rd_data_o
);

  logic [23:0] mem [StoreDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.color;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

### rtl/prfs_seq.sv
module prfs_seq
  import prfs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       opcode_i,
  input  logic [10:0]      x_start_i,
  input  logic [10:0]      y_start_i,
  input  logic [10:0]      x_end_i,
  input  logic [10:0]      y_end_i,
  input  logic [8:0]       radius_i,
  input  logic [23:0]      draw_color_i,
  input  logic [3:0]       bold_half_i,
  input  logic [11:0]      ring_band_i,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [23:0]      read_color_o,
  output logic [19:0]      pixels_written_o,
  output pix_wr_t          wr_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [23:0]      rd_data_i,
  output div_req_t         div_req_o,
  input  div_rsp_t         div_rsp_i
);

  state_e state_q, state_d;
  logic [2:0]  op_q;
  logic signed [11:0] x0_q, y0_q, x1_q, y1_q;
  logic [8:0]  rad_q;
  logic [23:0] col_q;
  logic [3:0]  h_q;
  logic [11:0] band_q;
  logic signed [11:0] cx_q, cy_q;
  logic signed [11:0] ly_q;
  logic signed [11:0] sa_q, sb_q;
  logic [1:0]  pass_q;
  logic [AddrW-1:0] clr_q;
  logic [19:0] cnt_q;
  logic [23:0] rdc_q;
  logic [21:0] prod_q;
  logic [21:0] rr_q;
  logic [1:0]  mstep_q;
  logic        neg_q;

  logic signed [11:0] px, py;
  logic        pen, inb;
  logic signed [12:0] dxs, dys;
  logic signed [12:0] mul_a;
  logic [21:0] mul_p;
  logic signed [23:0] f_val;
  logic        take;
  logic signed [11:0] span_x;
  logic signed [23:0] num_s;
  logic [AddrW-1:0] addr_c;
  logic rect_last, rect_empty, fill_last, fill_empty, circ_last;

  assign in_stall  = (state_q != StIdle);
  assign out_valid = (state_q == StDone);
  assign take      = in_valid && !in_stall;
  assign read_color_o     = rdc_q;
  assign pixels_written_o = cnt_q;

  assign dxs   = {cx_q[11], cx_q} - {x0_q[11], x0_q};
  assign dys   = {cy_q[11], cy_q} - {y0_q[11], y0_q};
  assign mul_a = (mstep_q == 2'd0) ? dxs :
                 (mstep_q == 2'd1) ? dys : $signed({4'b0, rad_q});
  assign mul_p = 22'(mul_a) * 22'(mul_a);
  assign f_val = $signed({2'b0, prod_q}) - $signed({2'b0, rr_q});

  assign span_x = x1_q - x0_q;
  assign num_s  = 24'(y1_q - y0_q) * 24'(cx_q - x0_q);

  assign rect_empty = 1'b0;
  assign rect_last  = (pass_q == 2'd3) && (cy_q >= y0_q || y1_q > y0_q);
  assign fill_empty = (x0_q > x1_q) || (y1_q > y0_q);
  assign fill_last  = (cx_q == x1_q) && (cy_q == y0_q);
  assign circ_last  = (cx_q == x0_q + $signed({3'b0, rad_q})) &&
                      (cy_q == y0_q + $signed({3'b0, rad_q}));

  always_comb begin
    px  = cx_q;
    py  = cy_q;
    pen = 1'b0;
    unique case (state_q)
      StLineX: begin
        pen = (x0_q == x1_q) && (op_q == OpLine);
        py  = y0_q;
      end
      StLineDiv: begin
        pen = div_rsp_i.done && (op_q == OpLine);
        py  = 12'(neg_q ? -$signed({1'b0, div_rsp_i.quo[10:0]})
                        : $signed({1'b0, div_rsp_i.quo[10:0]})) + y0_q;
      end
      StStamp: begin
        pen = 1'b1;
        px  = cx_q + sa_q;
        py  = ly_q + sb_q;
      end
      StRectPass: begin
        pen = pass_q[1] ? (cy_q <= y0_q) : (cx_q <= x1_q);
        unique case (pass_q)
          2'd0: begin px = cx_q; py = y0_q; end
          2'd1: begin px = cx_q; py = y1_q; end
          2'd2: begin px = x0_q; py = cy_q; end
          default: begin px = x1_q; py = cy_q; end
        endcase
      end
      StFill: pen = !fill_empty;
      StCircTest: pen = (f_val <= $signed({12'b0, band_q})) &&
                        (f_val >= -$signed({12'b0, band_q}));
      default: pen = 1'b0;
    endcase
    inb = (px >= 0) && (py >= 0) && (px < 12'(FrameWidth)) && (py < 12'(FrameHeight));
    addr_c = AddrW'(px[XW-1:0]) + AddrW'(py[YW-1:0]) * AddrW'(FrameWidth);
  end

  always_comb begin
    wr_o.en    = (pen && inb) || (state_q == StClear);
    wr_o.addr  = (state_q == StClear) ? clr_q : addr_c;
    wr_o.color = col_q;
    rd_addr_o  = AddrW'(x0_q[XW-1:0]) + AddrW'(y0_q[YW-1:0]) * AddrW'(FrameWidth);
    div_req_o.start   = (state_q == StLineX) && (x0_q != x1_q);
    div_req_o.num_mag = 22'(num_s[23] ? -num_s : num_s);
    div_req_o.den     = span_x;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (take) begin
        unique case (opcode_e'(opcode_i))
          OpClear: state_d = StClear;
          OpLine, OpBold: state_d = StLineX;
          OpRect: state_d = StRectPass;
          OpFill: state_d = StFill;
          OpCircle: state_d = StCircMul;
          OpRead: state_d = StReadWait;
          default: state_d = StDone;
        endcase
      end
      StClear: if (clr_q == AddrW'(StoreDepth - 1)) state_d = StDone;
      StLineX: begin
        if (cx_q > x1_q) state_d = StDone;
        else if (x0_q == x1_q) state_d = (op_q == OpBold) ? StStamp : StDone;
        else state_d = StLineDiv;
      end
      StLineDiv: if (div_rsp_i.done) begin
        if (op_q == OpBold) state_d = StStamp;
        else if (cx_q == x1_q) state_d = StDone;
        else state_d = StLineX;
      end
      StStamp: if (sa_q == $signed({8'b0, h_q}) && sb_q == $signed({8'b0, h_q})) begin
        if (x0_q == x1_q || cx_q == x1_q) state_d = StDone;
        else state_d = StLineX;
      end
      StRectPass: state_d = StRectPass;
      StFill: state_d = StFill;
      StCircMul: if (mstep_q == 2'd2) state_d = StCircTest;
      StCircTest: state_d = StCircMul;
      StReadWait: state_d = StReadData;
      StReadData: state_d = StDone;
      StDone: if (!out_stall) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    // Rectangle, fill and circle walks end on their own bounds.
    if (state_q == StRectPass) begin
      if (pass_q[1] == 1'b0) begin
        if (cx_q >= x1_q) state_d = (pass_q == 2'd1) ? StRectPass : StRectPass;
      end
      if (rect_last) state_d = StDone;
    end
    if (state_q == StFill && fill_last) state_d = StDone;
    if (state_q == StCircTest && circ_last) state_d = StDone;
    if (state_q == StRectPass && rect_empty) state_d = StDone;
    if (state_q == StFill && fill_empty) state_d = StDone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q   <= opcode_i;
      x0_q   <= {x_start_i[10], x_start_i};
      y0_q   <= {y_start_i[10], y_start_i};
      x1_q   <= {x_end_i[10], x_end_i};
      y1_q   <= {y_end_i[10], y_end_i};
      rad_q  <= radius_i;
      col_q  <= draw_color_i;
      h_q    <= bold_half_i;
      band_q <= ring_band_i;
      cnt_q  <= '0;
      rdc_q  <= '0;
      clr_q  <= '0;
      pass_q <= '0;
      mstep_q <= '0;
      unique case (opcode_e'(opcode_i))
        OpRect: begin
          cx_q <= {x_start_i[10], x_start_i};
          cy_q <= {y_end_i[10], y_end_i};
        end
        OpFill: begin
          cx_q <= {x_start_i[10], x_start_i};
          cy_q <= {y_end_i[10], y_end_i};
        end
        OpCircle: begin
          cx_q <= {x_start_i[10], x_start_i} - $signed({3'b0, radius_i});
          cy_q <= {y_start_i[10], y_start_i} - $signed({3'b0, radius_i});
        end
        default: begin
          cx_q <= {x_start_i[10], x_start_i};
          cy_q <= {y_start_i[10], y_start_i};
        end
      endcase
    end else begin
      if (wr_o.en && cnt_q != CountMax) cnt_q <= cnt_q + 20'd1;
      unique case (state_q)
        StClear: clr_q <= clr_q + AddrW'(1);
        StLineX: begin
          neg_q <= num_s[23] ^ span_x[11];
          ly_q  <= y0_q;
          sa_q  <= -$signed({8'b0, h_q});
          sb_q  <= -$signed({8'b0, h_q});
        end
        StLineDiv: if (div_rsp_i.done) begin
          ly_q <= py;
          if (op_q != OpBold) cx_q <= cx_q + 12'sd1;
        end
        StStamp: begin
          if (sb_q == $signed({8'b0, h_q})) begin
            sb_q <= -$signed({8'b0, h_q});
            sa_q <= sa_q + 12'sd1;
            if (sa_q == $signed({8'b0, h_q})) cx_q <= cx_q + 12'sd1;
          end else begin
            sb_q <= sb_q + 12'sd1;
          end
        end
        StRectPass: begin
          if (pass_q[1] == 1'b0) begin
            if (cx_q >= x1_q) begin
              pass_q <= pass_q + 2'd1;
              cx_q   <= x0_q;
              cy_q   <= y1_q;
            end else cx_q <= cx_q + 12'sd1;
          end else begin
            if (cy_q >= y0_q) begin
              pass_q <= pass_q + 2'd1;
              cy_q   <= y1_q;
            end else cy_q <= cy_q + 12'sd1;
          end
        end
        StFill: begin
          if (cy_q == y0_q) begin
            cy_q <= y1_q;
            cx_q <= cx_q + 12'sd1;
          end else cy_q <= cy_q + 12'sd1;
        end
        StCircMul: begin
          mstep_q <= mstep_q + 2'd1;
          unique case (mstep_q)
            2'd0: prod_q <= mul_p;
            2'd1: prod_q <= prod_q + mul_p;
            default: rr_q <= mul_p;
          endcase
        end
        StCircTest: begin
          mstep_q <= '0;
          if (cy_q == y0_q + $signed({3'b0, rad_q})) begin
            cy_q <= y0_q - $signed({3'b0, rad_q});
            cx_q <= cx_q + 12'sd1;
          end else cy_q <= cy_q + 12'sd1;
        end
        StReadData: if (x0_q >= 0 && y0_q >= 0 && x0_q < 12'(FrameWidth) &&
                        y0_q < 12'(FrameHeight)) rdc_q <= rd_data_i;
        default: ;
      endcase
    end
  end

endmodule

### rtl/prfs_checker.sv
`include "assert_macros.svh"

module prfs_checker
  import prfs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  opcode_i,
  input logic [19:0] pixels_written_o
);

  logic take;
  logic read_take;

  assign take      = in_valid && !in_stall;
  assign read_take = take && (opcode_i == OpRead);

  `ASSERT_IMPL(a_busy_after_take, clk_i, rst_ni, take |=> in_stall)
  `ASSERT_IMPL(a_no_take_with_result, clk_i, rst_ni, out_valid |-> in_stall)
  `ASSERT_STABLE(a_count_held, clk_i, rst_ni, (out_valid && out_stall), pixels_written_o)
  `ASSERT_IMPL(a_read_no_count, clk_i, rst_ni, read_take |=> (pixels_written_o == 20'd0))

endmodule

bind primitive_rasterizer_frame_store prfs_checker u_chk (.*);

### tb/sv/primitive_rasterizer_frame_store_tb.sv
module primitive_rasterizer_frame_store_tb;
  import prfs_pkg::*;

  typedef struct {
    opcode_e            op;
    logic signed [10:0] xs;
    logic signed [10:0] ys;
    logic signed [10:0] xe;
    logic signed [10:0] ye;
    logic [8:0]         rad;
    logic [23:0]        color;
    bit                 typed;
    logic [23:0]        typed_rd;
    logic [19:0]        typed_cnt;
  } draw_cmd_t;

  typedef struct {
    logic [23:0] rd;
    logic [19:0] cnt;
  } draw_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [11:0] cfg_data_i;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  opcode_i;
  logic [10:0] x_start_i;
  logic [10:0] y_start_i;
  logic [10:0] x_end_i;
  logic [10:0] y_end_i;
  logic [8:0]  radius_i;
  logic [23:0] draw_color_i;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] read_color_o;
  logic [19:0] pixels_written_o;

  logic [23:0]  pix_mem [StoreDepth];
  int           bold_h;
  int           band;
  int           plot_cnt;
  draw_result_t result_q[$];
  int           err_cnt;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_left;

  primitive_rasterizer_frame_store u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode_i        (opcode_i),
    .x_start_i       (x_start_i),
    .y_start_i       (y_start_i),
    .x_end_i         (x_end_i),
    .y_end_i         (y_end_i),
    .radius_i        (radius_i),
    .draw_color_i    (draw_color_i),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_color_o    (read_color_o),
    .pixels_written_o(pixels_written_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic plot(input int x, input int y, input logic [23:0] c);
    if (x >= 0 && y >= 0 && x < FrameWidth && y < FrameHeight) begin
      pix_mem[x + FrameWidth * y] = c;
      plot_cnt++;
    end
  endtask

  task automatic plot_square(input int x, input int y, input int h, input logic [23:0] c);
    for (int a = x - h; a <= x + h; a++) begin
      for (int b = y - h; b <= y + h; b++) plot(a, b, c);
    end
  endtask

  task automatic rasterize(input draw_cmd_t c, output draw_result_t r);
    int x0, y0, x1, y1, rr, f, yl, h;
    x0 = int'(c.xs);
    y0 = int'(c.ys);
    x1 = int'(c.xe);
    y1 = int'(c.ye);
    rr = int'(c.rad);
    h = (c.op == OpBold) ? bold_h : 0;
    plot_cnt = 0;
    r.rd = '0;
    case (c.op)
      OpClear: begin
        for (int i = 0; i < StoreDepth; i++) pix_mem[i] = c.color;
        plot_cnt = StoreDepth;
      end
      OpLine, OpBold: begin
        if (x0 == x1) begin
          plot_square(x0, y0, h, c.color);
        end else if (x0 < x1) begin
          for (int x = x0; x <= x1; x++) begin
            yl = (y1 - y0) * (x - x0) / (x1 - x0) + y0;
            plot_square(x, yl, h, c.color);
          end
        end
      end
      OpRect: begin
        for (int x = x0; x <= x1; x++) plot(x, y0, c.color);
        for (int x = x0; x <= x1; x++) plot(x, y1, c.color);
        for (int y = y1; y <= y0; y++) plot(x0, y, c.color);
        for (int y = y1; y <= y0; y++) plot(x1, y, c.color);
      end
      OpFill: begin
        for (int x = x0; x <= x1; x++) begin
          for (int y = y1; y <= y0; y++) plot(x, y, c.color);
        end
      end
      OpCircle: begin
        for (int x = x0 - rr; x <= x0 + rr; x++) begin
          for (int y = y0 - rr; y <= y0 + rr; y++) begin
            f = (x - x0) * (x - x0) + (y - y0) * (y - y0) - rr * rr;
            if (f <= band && f >= -band) plot(x, y, c.color);
          end
        end
      end
      OpRead: begin
        if (x0 >= 0 && y0 >= 0 && x0 < FrameWidth && y0 < FrameHeight) begin
          r.rd = pix_mem[x0 + FrameWidth * y0];
        end
      end
      default: ;
    endcase
    r.cnt = (plot_cnt > CountMax) ? CountMax : plot_cnt[19:0];
  endtask

  task automatic send_cmd(input draw_cmd_t c);
    draw_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    opcode_i <= c.op;
    x_start_i <= c.xs;
    y_start_i <= c.ys;
    x_end_i <= c.xe;
    y_end_i <= c.ye;
    radius_i <= c.rad;
    draw_color_i <= c.color;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    rasterize(c, r);
    if (c.typed) begin
      r.rd = c.typed_rd;
      r.cnt = c.typed_cnt;
    end
    result_q.push_back(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegBoldHalf) bold_h = int'(val[3:0]);
    else band = int'(val);
  endtask

  function automatic logic signed [10:0] clip11(input int v);
    if (v > 1023) return 11'sd1023;
    if (v < -1024) return -11'sd1024;
    return v[10:0];
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(99) < 25) return int'($urandom_range(2047)) - 1024;
    return int'($urandom_range(680)) - 20;
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int sel, xs, ys, span;
    sel = $urandom_range(99);
    xs = pick_coord();
    ys = pick_coord();
    c.typed = 1'b0;
    c.typed_rd = '0;
    c.typed_cnt = '0;
    c.rad = 9'($urandom_range(511));
    c.color = 24'($urandom());
    c.xs = clip11(xs);
    c.ys = clip11(ys);
    c.xe = clip11(xs + int'($urandom_range(100)) - 10);
    c.ye = clip11(ys + int'($urandom_range(200)) - 100);
    if (sel < 16) begin
      c.op = OpLine;
    end else if (sel < 30) begin
      c.op = OpBold;
      span = (bold_h > 8) ? 10 : 30;
      c.xe = clip11(xs + int'($urandom_range(span)) - 3);
      c.ye = clip11(ys + int'($urandom_range(2 * span)) - span);
    end else if (sel < 44) begin
      c.op = OpRect;
      c.xe = clip11(xs + int'($urandom_range(150)) - 5);
      c.ye = clip11(ys - int'($urandom_range(150)) + 5);
    end else if (sel < 58) begin
      c.op = OpFill;
      c.xe = clip11(xs + int'($urandom_range(33)) - 3);
      c.ye = clip11(ys - int'($urandom_range(33)) + 3);
    end else if (sel < 72) begin
      c.op = OpCircle;
      c.rad = 9'($urandom_range(40));
    end else if (sel < 97) begin
      c.op = OpRead;
    end else begin
      c.op = OpNone;
      c.xs = 11'($urandom());
      c.ys = 11'($urandom());
      c.xe = 11'($urandom());
      c.ye = 11'($urandom());
    end
    return c;
  endfunction

  function automatic draw_cmd_t row(input opcode_e op, input int xs, input int ys,
                                    input int xe, input int ye, input int rad,
                                    input logic [23:0] color, input bit typed,
                                    input logic [23:0] trd, input int tcnt);
    draw_cmd_t c;
    c.op = op;
    c.xs = xs[10:0];
    c.ys = ys[10:0];
    c.xe = xe[10:0];
    c.ye = ye[10:0];
    c.rad = rad[8:0];
    c.color = color;
    c.typed = typed;
    c.typed_rd = trd;
    c.typed_cnt = tcnt[19:0];
    return c;
  endfunction

  always @(posedge clk_i) begin
    draw_result_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("unexpected result transfer: read_color %h pixels_written %0d",
               read_color_o, pixels_written_o);
        err_cnt++;
      end else begin
        e = result_q.pop_front();
        if (read_color_o !== e.rd) begin
          $error("read_color: expected %h actual %h", e.rd, read_color_o);
          err_cnt++;
        end
        if (pixels_written_o !== e.cnt) begin
          $error("pixels_written: expected %0d actual %0d", e.cnt, pixels_written_o);
          err_cnt++;
        end
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #400_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    draw_cmd_t tbl[$];
    err_cnt = 0;
    hold_left = 0;
    bold_h = 5;
    band = 50;
    send_idle_pct = 17;
    recv_stall_pct = 77;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = RegBoldHalf;
    cfg_data_i = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    opcode_i = OpNone;
    x_start_i = '0;
    y_start_i = '0;
    x_end_i = '0;
    y_end_i = '0;
    radius_i = '0;
    draw_color_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tbl.push_back(row(OpClear, 0, 0, 0, 0, 0, 24'hFFFFFF, 1, 24'h0, StoreDepth));
    tbl.push_back(row(OpRead, 0, 0, 0, 0, 0, 24'h0, 1, 24'hFFFFFF, 0));
    tbl.push_back(row(OpRead, 639, 479, 0, 0, 0, 24'h0, 1, 24'hFFFFFF, 0));
    tbl.push_back(row(OpRead, 640, 0, 0, 0, 0, 24'h0, 1, 24'h0, 0));
    tbl.push_back(row(OpRead, -1024, -1024, 0, 0, 0, 24'h0, 1, 24'h0, 0));
    tbl.push_back(row(OpLine, 0, 0, 639, 479, 0, 24'h123456, 0, 24'h0, 0));
    tbl.push_back(row(OpLine, 10, 5, 3, 7, 0, 24'hABCDEF, 1, 24'h0, 0));
    tbl.push_back(row(OpLine, 100, 100, 100, 300, 0, 24'h00FF00, 1, 24'h0, 1));
    tbl.push_back(row(OpBold, 200, 200, 200, 50, 0, 24'h0000FF, 1, 24'h0, 121));
    tbl.push_back(row(OpBold, -5, -5, 20, 30, 0, 24'hFF0000, 0, 24'h0, 0));
    tbl.push_back(row(OpRect, 10, 50, 60, 20, 0, 24'h777777, 0, 24'h0, 0));
    tbl.push_back(row(OpRect, 60, 20, 10, 50, 0, 24'h888888, 0, 24'h0, 0));
    tbl.push_back(row(OpFill, 0, 479, 639, 470, 0, 24'h00FFFF, 1, 24'h0, 6400));
    tbl.push_back(row(OpFill, 1000, 1023, 1023, 1000, 0, 24'h111111, 1, 24'h0, 0));
    tbl.push_back(row(OpCircle, 320, 240, 0, 0, 0, 24'hFF00FF, 1, 24'h0, 1));
    tbl.push_back(row(OpCircle, 320, 240, 0, 0, 20, 24'h00AA00, 0, 24'h0, 0));
    tbl.push_back(row(OpCircle, 0, 0, 0, 0, 30, 24'hAA0000, 0, 24'h0, 0));
    tbl.push_back(row(OpRead, 320, 240, 0, 0, 0, 24'h0, 0, 24'h0, 0));
    tbl.push_back(row(OpNone, 1023, 1023, -1024, -1024, 511, 24'hFFFFFF, 1, 24'h0, 0));
    tbl.push_back(row(OpClear, 0, 0, 0, 0, 0, 24'h000000, 1, 24'h0, StoreDepth));
    tbl.push_back(row(OpRead, 5, 5, 0, 0, 0, 24'h0, 1, 24'h0, 0));
    tbl.push_back(row(OpLine, -1024, 1023, 1023, -1024, 0, 24'h5A5A5A, 0, 24'h0, 0));
    tbl.push_back(row(OpRead, 0, 0, 0, 0, 0, 24'h0, 0, 24'h0, 0));
    foreach (tbl[i]) send_cmd(tbl[i]);
    drain();

    write_reg(RegBoldHalf, 12'd0);
    write_reg(RegRingBand, 12'd4095);
    repeat (200) send_cmd(random_cmd());
    drain();

    send_idle_pct = 77;
    recv_stall_pct = 17;
    write_reg(RegBoldHalf, 12'd15);
    write_reg(RegRingBand, 12'd0);
    repeat (200) send_cmd(random_cmd());
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(RegBoldHalf, 12'd9);
    write_reg(RegRingBand, 12'd300);
    hold_left = 400;
    repeat (200) send_cmd(random_cmd());
    drain();

    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
